// File: hdl/trs_pkg.sv
// Shared types and constants for the TRS model matrix unit.
// Used by trs_trig and trs_model_matrix_unit; depends on nothing.

package trs_pkg;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] angle_x;
		logic signed [15:0] angle_y;
		logic signed [15:0] angle_z;
		logic signed [31:0] scale_x;
		logic signed [31:0] scale_y;
		logic signed [31:0] scale_z;
	} item_t;

	typedef struct packed {
		logic signed [31:0] m_r0c0;
		logic signed [31:0] m_r0c1;
		logic signed [31:0] m_r0c2;
		logic signed [31:0] m_r1c0;
		logic signed [31:0] m_r1c1;
		logic signed [31:0] m_r1c2;
		logic signed [31:0] m_r2c0;
		logic signed [31:0] m_r2c1;
		logic signed [31:0] m_r2c2;
		logic signed [31:0] trans_x;
		logic signed [31:0] trans_y;
		logic signed [31:0] trans_z;
	} mtx_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} vec3_t;

	// pipeline depth: sine/cosine unit, then matrix assembly
	localparam int TRIG_ST = 22;
	localparam int MAT_ST  = 6;
	localparam int PIPE_ST = TRIG_ST + MAT_ST;

	localparam int FULL_TURN    = 23040;
	localparam int QUARTER_TURN = 5760;
	localparam int EIGHTH_TURN  = 2880;

	// pi in Q32 split as 11520 * PI_A + PI_B
	localparam int PI_A  = 1171270;
	localparam int PI_B  = 7305;
	localparam int X_RND = 5760;
	localparam int DIV45 = 45;
	localparam int R45   = (1 << 17) / 45;

	localparam logic [32:0] Q32_ONE33 = 33'h1_0000_0000;

	localparam int SIN_N = 4;
	localparam int COS_N = 5;
	localparam logic [6:0] SIN_DIV [SIN_N] = '{7'd72, 7'd42, 7'd20, 7'd6};
	localparam logic [6:0] COS_DIV [COS_N] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};
	localparam logic [31:0] SIN_RCP [SIN_N] = '{
		32'((64'd1 << 32) / 64'd72), 32'((64'd1 << 32) / 64'd42),
		32'((64'd1 << 32) / 64'd20), 32'((64'd1 << 32) / 64'd6)};
	localparam logic [31:0] COS_RCP [COS_N] = '{
		32'((64'd1 << 32) / 64'd90), 32'((64'd1 << 32) / 64'd56),
		32'((64'd1 << 32) / 64'd30), 32'((64'd1 << 32) / 64'd12),
		32'((64'd1 << 32) / 64'd2)};

endpackage

// File: hdl/trs_trig.sv
// Pipelined sine/cosine of an angle in 1/64 degree, signed Q30 results.
// Octant reduction, then Horner Taylor series; depends on trs_pkg.

module trs_trig (
	input  logic                            clk,
	input  logic [trs_pkg::TRIG_ST-1:0]     en,
	input  logic signed [15:0]              angle,
	output logic signed [31:0]              sn,
	output logic signed [31:0]              cs
);

	localparam int STEP_BASE = 6;
	localparam int SIN_FIN   = STEP_BASE + 3 * trs_pkg::SIN_N;
	localparam int OUT_ST    = trs_pkg::TRIG_ST - 1;
	localparam int X2_LAST   = STEP_BASE + 3 * (trs_pkg::COS_N - 1) - 1;

	function automatic logic [31:0] mulq32(input logic [31:0] a, input logic [32:0] b);
		logic [64:0] p;
		p = {33'd0, a} * {32'd0, b} + (65'd1 << 31);
		return p[63:32];
	endfunction

	function automatic logic [31:0] rcpq(input logic [31:0] m, input logic [31:0] rc);
		logic [63:0] p;
		p = {32'd0, m} * {32'd0, rc};
		return p[63:32];
	endfunction

	// estimate is at most one low: one compare fixes it
	function automatic logic [32:0] step_t(input logic [31:0] m, input logic [31:0] qe,
			input logic [6:0] d);
		logic [31:0] rem;
		logic [31:0] q;
		rem = m - 32'(qe * {25'd0, d});
		q = qe + 32'(rem >= {25'd0, d});
		return trs_pkg::Q32_ONE33 - {1'b0, q};
	endfunction

	logic [14:0]  r_s0;
	logic [1:0]   quad_s [1:OUT_ST-1];
	logic         sw_s [1:OUT_ST-1];
	logic [11:0]  fo_s1;
	logic [31:0]  fa_s2, fa_s3;
	logic [16:0]  fb_s2, fb_s3;
	logic [11:0]  qe_s3;
	logic [31:0]  x_s [4:SIN_FIN-1];
	logic [31:0]  x2_s [5:X2_LAST];
	logic [31:0]  sn_s [SIN_FIN:OUT_ST-1];
	logic [31:0]  cm_a [trs_pkg::COS_N];
	logic [31:0]  cm_b [trs_pkg::COS_N];
	logic [31:0]  cq_b [trs_pkg::COS_N];
	logic [32:0]  ct_c [trs_pkg::COS_N];
	logic [31:0]  sm_a [trs_pkg::SIN_N];
	logic [31:0]  sm_b [trs_pkg::SIN_N];
	logic [31:0]  sq_b [trs_pkg::SIN_N];
	logic [32:0]  st_c [trs_pkg::SIN_N];

	logic signed [17:0] a_w, r_w;
	logic [1:0]   quad_w;
	logic [14:0]  base_w;
	logic [12:0]  f_w;
	logic         sw_w;
	logic [11:0]  fo_w;
	logic [16:0]  rem45_w;
	logic [11:0]  q45_w;
	logic [32:0]  s_w, c_w;
	logic signed [31:0] s30_w, c30_w;

	localparam logic signed [17:0] FT18 = 18'(trs_pkg::FULL_TURN);

	// wrap to one full turn
	always_comb begin
		a_w = 18'(angle);
		if (a_w < 18'sd0) begin
			r_w = (a_w + FT18 >= 18'sd0) ? a_w + FT18 : a_w + FT18 + FT18;
		end else begin
			r_w = (a_w >= FT18) ? a_w - FT18 : a_w;
		end
	end

	// quadrant and first-octant fold
	always_comb begin
		if (r_s0 >= 15'(3 * trs_pkg::QUARTER_TURN)) quad_w = 2'd3;
		else if (r_s0 >= 15'(2 * trs_pkg::QUARTER_TURN)) quad_w = 2'd2;
		else if (r_s0 >= 15'(trs_pkg::QUARTER_TURN)) quad_w = 2'd1;
		else quad_w = 2'd0;
		base_w = 15'(trs_pkg::QUARTER_TURN) * {13'd0, quad_w};
		f_w = 13'(r_s0 - base_w);
		sw_w = f_w > 13'(trs_pkg::EIGHTH_TURN);
		fo_w = sw_w ? 12'(13'(trs_pkg::QUARTER_TURN) - f_w) : f_w[11:0];
	end

	always_comb begin
		rem45_w = fb_s3 - 17'(qe_s3 * 17'(trs_pkg::DIV45));
		q45_w = qe_s3 + 12'(rem45_w >= 17'(trs_pkg::DIV45));
	end

	always_ff @(posedge clk) begin
		if (en[0]) r_s0 <= r_w[14:0];
		if (en[1]) begin
			quad_s[1] <= quad_w;
			sw_s[1]   <= sw_w;
			fo_s1     <= fo_w;
		end
		for (int i = 2; i <= OUT_ST - 1; i++) begin
			if (en[i]) begin
				quad_s[i] <= quad_s[i-1];
				sw_s[i]   <= sw_s[i-1];
			end
		end
		if (en[2]) begin
			fa_s2 <= 32'(33'(fo_s1) * 33'(trs_pkg::PI_A));
			fb_s2 <= 17'((25'(fo_s1) * 25'(trs_pkg::PI_B) + 25'(trs_pkg::X_RND)) >> 8);
		end
		if (en[3]) begin
			fa_s3 <= fa_s2;
			fb_s3 <= fb_s2;
			qe_s3 <= 12'((29'(fb_s2) * 29'(trs_pkg::R45)) >> 17);
		end
		if (en[4]) x_s[4] <= fa_s3 + 32'(q45_w);
		for (int i = 5; i <= SIN_FIN - 1; i++) begin
			if (en[i]) x_s[i] <= x_s[i-1];
		end
		if (en[5]) x2_s[5] <= mulq32(x_s[4], {1'b0, x_s[4]});
		for (int i = 6; i <= X2_LAST; i++) begin
			if (en[i]) x2_s[i] <= x2_s[i-1];
		end
		if (en[SIN_FIN]) sn_s[SIN_FIN] <= mulq32(x_s[SIN_FIN-1], st_c[trs_pkg::SIN_N-1]);
		for (int i = SIN_FIN + 1; i <= OUT_ST - 1; i++) begin
			if (en[i]) sn_s[i] <= sn_s[i-1];
		end
	end

	for (genvar j = 0; j < trs_pkg::COS_N; j++) begin : g_cos
		localparam int SA = STEP_BASE + 3 * j;
		logic [32:0] t_in;
		if (j == 0) begin : g_first
			assign t_in = trs_pkg::Q32_ONE33;
		end else begin : g_next
			assign t_in = ct_c[j-1];
		end
		always_ff @(posedge clk) begin
			if (en[SA]) cm_a[j] <= mulq32(x2_s[SA-1], t_in);
			if (en[SA+1]) begin
				cq_b[j] <= rcpq(cm_a[j], trs_pkg::COS_RCP[j]);
				cm_b[j] <= cm_a[j];
			end
			if (en[SA+2]) ct_c[j] <= step_t(cm_b[j], cq_b[j], trs_pkg::COS_DIV[j]);
		end
	end

	for (genvar j = 0; j < trs_pkg::SIN_N; j++) begin : g_sin
		localparam int SA = STEP_BASE + 3 * j;
		logic [32:0] t_in;
		if (j == 0) begin : g_first
			assign t_in = trs_pkg::Q32_ONE33;
		end else begin : g_next
			assign t_in = st_c[j-1];
		end
		always_ff @(posedge clk) begin
			if (en[SA]) sm_a[j] <= mulq32(x2_s[SA-1], t_in);
			if (en[SA+1]) begin
				sq_b[j] <= rcpq(sm_a[j], trs_pkg::SIN_RCP[j]);
				sm_b[j] <= sm_a[j];
			end
			if (en[SA+2]) st_c[j] <= step_t(sm_b[j], sq_b[j], trs_pkg::SIN_DIV[j]);
		end
	end

	// undo the octant fold, round to Q30, apply quadrant
	always_comb begin
		s_w = sw_s[OUT_ST-1] ? ct_c[trs_pkg::COS_N-1] : {1'b0, sn_s[OUT_ST-1]};
		c_w = sw_s[OUT_ST-1] ? {1'b0, sn_s[OUT_ST-1]} : ct_c[trs_pkg::COS_N-1];
		s30_w = $signed(32'((34'(s_w) + 34'd2) >> 2));
		c30_w = $signed(32'((34'(c_w) + 34'd2) >> 2));
	end

	always_ff @(posedge clk) begin
		if (en[OUT_ST]) begin
			case (quad_s[OUT_ST-1])
				2'd0: begin
					sn <= s30_w;
					cs <= c30_w;
				end
				2'd1: begin
					sn <= c30_w;
					cs <= -s30_w;
				end
				2'd2: begin
					sn <= -s30_w;
					cs <= -c30_w;
				end
				default: begin
					sn <= -c30_w;
					cs <= s30_w;
				end
			endcase
		end
	end

endmodule

// File: hdl/trs_model_matrix_unit.sv
// Top level: TRS model matrix T * Ry * Rx * Rz * S, Q16.16 saturated.
// Uses trs_pkg and three trs_trig units, one per Euler angle.
//
//  channel  | direction | payload          | handshake
//  ---------+-----------+------------------+-------------------------
//  item     | in        | trs_pkg::item_t  | item_valid / item_stall
//  mtx      | out       | trs_pkg::mtx_t   | mtx_valid / mtx_stall
//
// One transaction per cycle while mtx_stall is low. The sine/cosine series
// pipeline, whose depth is set by the Horner chain of the cosine series,
// feeds matrix assembly. Each stage holds only when it is full and the stage
// after it holds, so bubbles close up while the output is stalled.
// Reset clears the valid bits only.

module trs_model_matrix_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  trs_pkg::item_t  item,
	output logic            mtx_valid,
	input  logic            mtx_stall,
	output trs_pkg::mtx_t   mtx
);

	localparam int NS = trs_pkg::PIPE_ST;
	localparam int TS = trs_pkg::TRIG_ST;

	localparam logic signed [34:0] SMAX = 35'sd2147483647;
	localparam logic signed [34:0] SMIN = -35'sd2147483648;

	function automatic logic signed [34:0] rnd30(input logic signed [64:0] v);
		logic [64:0] m;
		logic [64:0] r;
		m = v[64] ? 65'(-v) : 65'(v);
		r = (m + (65'd1 << 29)) >> 30;
		return v[64] ? -$signed(35'(r)) : $signed(35'(r));
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
		if (v > SMAX) return 32'sh7fffffff;
		if (v < SMIN) return 32'sh80000000;
		return v[31:0];
	endfunction

	logic [NS-1:0] vld_s;
	logic [NS-1:0] en;
	logic [NS-1:0] lowm;

	trs_pkg::vec3_t tr_s [NS];
	trs_pkg::vec3_t sc_s [TS+4];

	logic signed [31:0] sx, cx, sy, cy, sz, cz;

	logic signed [63:0] sysx_p_s22, cysx_p_s22, cycz_p_s22, cysz_p_s22, sycx_p_s22;
	logic signed [63:0] cxsz_p_s22, cxcz_p_s22, sycz_p_s22, sysz_p_s22, cycx_p_s22;
	logic signed [31:0] sx_s22, sz_s22, cz_s22;
	logic signed [31:0] sysx_s23, cysx_s23, cycz_s23, cysz_s23, sycx_s23;
	logic signed [31:0] cxsz_s23, cxcz_s23, sycz_s23, sysz_s23, cycx_s23;
	logic signed [31:0] sx_s23, sz_s23, cz_s23;
	logic signed [63:0] a_p_s24, b_p_s24, c_p_s24, d_p_s24;
	logic signed [31:0] cycz_s24, cysz_s24, sycx_s24, cxsz_s24, cxcz_s24;
	logic signed [31:0] sycz_s24, sysz_s24, cycx_s24, sx_s24;
	logic signed [32:0] r_s25 [9];
	logic signed [64:0] pr_s26 [9];
	logic signed [31:0] m_s27 [9];
	logic signed [31:0] scl [3];

	// a stage may load unless it and everything after it is full and stalled
	always_comb begin
		for (int k = 0; k < NS; k++) begin
			lowm[k] = 1'b0;
		end
		for (int k = 0; k < NS; k++) begin
			lowm = NS'((64'd1 << k) - 64'd1);
			en[k] = !(mtx_stall && (&(vld_s | lowm)));
		end
	end

	assign item_stall = !en[0];
	assign mtx_valid  = vld_s[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) vld_s[0] <= item_valid;
			for (int k = 1; k < NS; k++) begin
				if (en[k]) vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			tr_s[0] <= '{x: item.pos_x, y: item.pos_y, z: item.pos_z};
			sc_s[0] <= '{x: item.scale_x, y: item.scale_y, z: item.scale_z};
		end
		for (int k = 1; k < NS; k++) begin
			if (en[k]) tr_s[k] <= tr_s[k-1];
		end
		for (int k = 1; k < TS + 4; k++) begin
			if (en[k]) sc_s[k] <= sc_s[k-1];
		end
	end

	trs_trig u_trig_x (.clk(clk), .en(en[TS-1:0]), .angle(item.angle_x), .sn(sx), .cs(cx));
	trs_trig u_trig_y (.clk(clk), .en(en[TS-1:0]), .angle(item.angle_y), .sn(sy), .cs(cy));
	trs_trig u_trig_z (.clk(clk), .en(en[TS-1:0]), .angle(item.angle_z), .sn(sz), .cs(cz));

	assign scl[0] = sc_s[TS+3].x;
	assign scl[1] = sc_s[TS+3].y;
	assign scl[2] = sc_s[TS+3].z;

	always_ff @(posedge clk) begin
		if (en[TS]) begin
			sysx_p_s22 <= sy * sx;
			cysx_p_s22 <= cy * sx;
			cycz_p_s22 <= cy * cz;
			cysz_p_s22 <= cy * sz;
			sycx_p_s22 <= sy * cx;
			cxsz_p_s22 <= cx * sz;
			cxcz_p_s22 <= cx * cz;
			sycz_p_s22 <= sy * cz;
			sysz_p_s22 <= sy * sz;
			cycx_p_s22 <= cy * cx;
			sx_s22 <= sx;
			sz_s22 <= sz;
			cz_s22 <= cz;
		end
		if (en[TS+1]) begin
			sysx_s23 <= 32'(rnd30(65'(sysx_p_s22)));
			cysx_s23 <= 32'(rnd30(65'(cysx_p_s22)));
			cycz_s23 <= 32'(rnd30(65'(cycz_p_s22)));
			cysz_s23 <= 32'(rnd30(65'(cysz_p_s22)));
			sycx_s23 <= 32'(rnd30(65'(sycx_p_s22)));
			cxsz_s23 <= 32'(rnd30(65'(cxsz_p_s22)));
			cxcz_s23 <= 32'(rnd30(65'(cxcz_p_s22)));
			sycz_s23 <= 32'(rnd30(65'(sycz_p_s22)));
			sysz_s23 <= 32'(rnd30(65'(sysz_p_s22)));
			cycx_s23 <= 32'(rnd30(65'(cycx_p_s22)));
			sx_s23 <= sx_s22;
			sz_s23 <= sz_s22;
			cz_s23 <= cz_s22;
		end
		// triple products: rounded pair times third factor
		if (en[TS+2]) begin
			a_p_s24 <= sysx_s23 * sz_s23;
			b_p_s24 <= sysx_s23 * cz_s23;
			c_p_s24 <= cysx_s23 * sz_s23;
			d_p_s24 <= cysx_s23 * cz_s23;
			cycz_s24 <= cycz_s23;
			cysz_s24 <= cysz_s23;
			sycx_s24 <= sycx_s23;
			cxsz_s24 <= cxsz_s23;
			cxcz_s24 <= cxcz_s23;
			sycz_s24 <= sycz_s23;
			sysz_s24 <= sysz_s23;
			cycx_s24 <= cycx_s23;
			sx_s24 <= sx_s23;
		end
		if (en[TS+3]) begin
			r_s25[0] <= 33'(cycz_s24) + 33'(rnd30(65'(a_p_s24)));
			r_s25[1] <= 33'(rnd30(65'(b_p_s24))) - 33'(cysz_s24);
			r_s25[2] <= 33'(sycx_s24);
			r_s25[3] <= 33'(cxsz_s24);
			r_s25[4] <= 33'(cxcz_s24);
			r_s25[5] <= -33'(sx_s24);
			r_s25[6] <= 33'(rnd30(65'(c_p_s24))) - 33'(sycz_s24);
			r_s25[7] <= 33'(sysz_s24) + 33'(rnd30(65'(d_p_s24)));
			r_s25[8] <= 33'(cycx_s24);
		end
		for (int rr = 0; rr < 3; rr++) begin
			for (int cc = 0; cc < 3; cc++) begin
				if (en[TS+4]) pr_s26[3*rr+cc] <= 65'(r_s25[3*rr+cc]) * 65'(scl[cc]);
				if (en[TS+5]) m_s27[3*rr+cc] <= sat32(rnd30(pr_s26[3*rr+cc]));
			end
		end
	end

	assign mtx.m_r0c0  = m_s27[0];
	assign mtx.m_r0c1  = m_s27[1];
	assign mtx.m_r0c2  = m_s27[2];
	assign mtx.m_r1c0  = m_s27[3];
	assign mtx.m_r1c1  = m_s27[4];
	assign mtx.m_r1c2  = m_s27[5];
	assign mtx.m_r2c0  = m_s27[6];
	assign mtx.m_r2c1  = m_s27[7];
	assign mtx.m_r2c2  = m_s27[8];
	assign mtx.trans_x = tr_s[NS-1].x;
	assign mtx.trans_y = tr_s[NS-1].y;
	assign mtx.trans_z = tr_s[NS-1].z;

`ifndef ASSERT_OFF
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		!mtx_valid |-> !item_stall)
		else $error("input stalled with an empty output stage");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		((&vld_s) && mtx_stall) |-> item_stall)
		else $error("input taken while every stage is full and stalled");

	a_trig: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[TS-1] |-> (sx <= 32'sd1073741824 && sx >= -32'sd1073741824 &&
			cy <= 32'sd1073741824 && cy >= -32'sd1073741824 &&
			sz <= 32'sd1073741824 && sz >= -32'sd1073741824))
		else $error("sine/cosine beyond unit magnitude");
`endif

endmodule

// File: tb/testbench.sv
// Testbench for trs_model_matrix_unit: random and directed TRS items, bit-exact
// prediction of the saturated Q16.16 model matrix, in-order comparison.
// Depends on trs_pkg and the RTL of trs_model_matrix_unit.
`timescale 1ns / 1ps

module testbench;

	localparam int N_RANDOM   = 400;
	localparam int WDOG_LIMIT = 20000;
	localparam int DRAIN_CYC  = 2 * trs_pkg::PIPE_ST;

	logic  clk;
	logic  arst_n;
	logic  item_valid;
	logic  item_stall;
	trs_pkg::item_t item;
	logic  mtx_valid;
	logic  mtx_stall;
	trs_pkg::mtx_t  mtx;

	trs_pkg::item_t pending_items[$];
	trs_pkg::mtx_t  expected_mtx[$];
	int    n_mismatch;
	int    n_sent;
	int    n_checked;
	int    idle_cycles;
	int    burst_left;
	int    gap_left;
	int    stall_phase;
	int    stall_mode;
	bit    stim_done;

	trs_model_matrix_unit dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.mtx_valid(mtx_valid), .mtx_stall(mtx_stall), .mtx(mtx)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// ---------------- predictor ----------------
	function automatic longint unsigned q32_mul(longint unsigned a, longint unsigned b);
		return (a * b + 64'h8000_0000) >> 32;
	endfunction

	function automatic longint round_away(longint v, int k);
		longint unsigned m;
		bit neg;
		neg = v < 0;
		m = neg ? longint'(-v) : v;
		m = (m + (64'd1 << (k - 1))) >> k;
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint q30_mul(longint a, longint b);
		return round_away(a * b, 30);
	endfunction

	function automatic void octant_sincos(longint f, output longint unsigned s,
			output longint unsigned c);
		longint unsigned sdiv[4];
		longint unsigned cdiv[5];
		longint unsigned x, x2, t;
		sdiv = '{72, 42, 20, 6};
		cdiv = '{90, 56, 30, 12, 2};
		x = (longint'(f) * 64'd13493037705 + 64'd5760) / 64'd11520;
		x2 = q32_mul(x, x);
		t = 64'h1_0000_0000;
		for (int i = 0; i < 4; i++)
			t = 64'h1_0000_0000 - q32_mul(x2, t) / sdiv[i];
		s = q32_mul(x, t);
		t = 64'h1_0000_0000;
		for (int i = 0; i < 5; i++)
			t = 64'h1_0000_0000 - q32_mul(x2, t) / cdiv[i];
		c = t;
	endfunction

	function automatic void angle_sincos(logic signed [15:0] a, output longint sn,
			output longint cs);
		longint r, q, f, s30, c30;
		longint unsigned s, c;
		r = longint'(a) % trs_pkg::FULL_TURN;
		if (r < 0)
			r += trs_pkg::FULL_TURN;
		q = r / trs_pkg::QUARTER_TURN;
		f = r % trs_pkg::QUARTER_TURN;
		if (f <= trs_pkg::EIGHTH_TURN)
			octant_sincos(f, s, c);
		else
			octant_sincos(trs_pkg::QUARTER_TURN - f, c, s);
		s30 = longint'((s + 2) >> 2);
		c30 = longint'((c + 2) >> 2);
		case (q)
			0: begin sn = s30;  cs = c30;  end
			1: begin sn = c30;  cs = -s30; end
			2: begin sn = -s30; cs = -c30; end
			default: begin sn = -c30; cs = s30; end
		endcase
	endfunction

	function automatic logic signed [31:0] scale_sat(longint r30, logic signed [31:0] scl);
		longint v;
		v = round_away(r30 * longint'(scl), 30);
		if (v > 64'sd2147483647)
			v = 64'sd2147483647;
		if (v < -64'sd2147483648)
			v = -64'sd2147483648;
		return v[31:0];
	endfunction

	function automatic trs_pkg::mtx_t model_matrix(trs_pkg::item_t it);
		longint sx, cx, sy, cy, sz, cz, sysx, cysx;
		longint r[9];
		trs_pkg::mtx_t m;
		angle_sincos(it.angle_x, sx, cx);
		angle_sincos(it.angle_y, sy, cy);
		angle_sincos(it.angle_z, sz, cz);
		sysx = q30_mul(sy, sx);
		cysx = q30_mul(cy, sx);
		r[0] = q30_mul(cy, cz) + q30_mul(sysx, sz);
		r[1] = q30_mul(sysx, cz) - q30_mul(cy, sz);
		r[2] = q30_mul(sy, cx);
		r[3] = q30_mul(cx, sz);
		r[4] = q30_mul(cx, cz);
		r[5] = -sx;
		r[6] = q30_mul(cysx, sz) - q30_mul(sy, cz);
		r[7] = q30_mul(sy, sz) + q30_mul(cysx, cz);
		r[8] = q30_mul(cy, cx);
		m.m_r0c0 = scale_sat(r[0], it.scale_x);
		m.m_r0c1 = scale_sat(r[1], it.scale_y);
		m.m_r0c2 = scale_sat(r[2], it.scale_z);
		m.m_r1c0 = scale_sat(r[3], it.scale_x);
		m.m_r1c1 = scale_sat(r[4], it.scale_y);
		m.m_r1c2 = scale_sat(r[5], it.scale_z);
		m.m_r2c0 = scale_sat(r[6], it.scale_x);
		m.m_r2c1 = scale_sat(r[7], it.scale_y);
		m.m_r2c2 = scale_sat(r[8], it.scale_z);
		m.trans_x = it.pos_x;
		m.trans_y = it.pos_y;
		m.trans_z = it.pos_z;
		return m;
	endfunction

	// ---------------- stimulus helpers ----------------
	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536);
			3: return 32'h0001_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] rand_angle();
		case ($urandom_range(0, 5))
			0: return 16'($signed($urandom_range(0, 8)) * trs_pkg::QUARTER_TURN / 2 - 23040);
			1: return 16'($urandom);
			default: return 16'($signed($urandom_range(0, 2 * trs_pkg::FULL_TURN)) -
				trs_pkg::FULL_TURN);
		endcase
	endfunction

	function automatic trs_pkg::item_t make_item(logic [15:0] ax, logic [15:0] ay,
			logic [15:0] az, logic [31:0] s);
		trs_pkg::item_t it;
		it.pos_x = rand_word();
		it.pos_y = rand_word();
		it.pos_z = rand_word();
		it.angle_x = ax;
		it.angle_y = ay;
		it.angle_z = az;
		it.scale_x = s;
		it.scale_y = s;
		it.scale_z = s;
		return it;
	endfunction

	initial begin
		trs_pkg::item_t it;
		logic [15:0] dir_angles[12];
		dir_angles = '{16'sd0, 16'sd5760, -16'sd5760, 16'sd11520, 16'sd23040, -16'sd23040,
			16'sd2880, 16'sd2881, 16'sd2879, 16'h7fff, 16'h8000, 16'hffff};
		// directed: special angles, unit and saturating scales
		foreach (dir_angles[i])
			pending_items.push_back(make_item(dir_angles[i], dir_angles[(i + 3) % 12],
				dir_angles[(i + 7) % 12], 32'h0001_0000));
		for (int i = 0; i < 4; i++) begin
			it = make_item(16'(2880 * i), 16'sd1000, -16'sd3000,
				i[0] ? 32'h7fff_ffff : 32'h8000_0000);
			it.pos_x = i[1] ? 32'h7fff_ffff : 32'h8000_0000;
			it.pos_y = 32'h0;
			it.pos_z = 32'hffff_ffff;
			pending_items.push_back(it);
		end
		pending_items.push_back(make_item(16'h7fff, 16'h8000, 16'h0001, 32'h0));
		for (int i = 0; i < N_RANDOM; i++) begin
			it = make_item(rand_angle(), rand_angle(), rand_angle(), rand_word());
			it.scale_y = rand_word();
			it.scale_z = rand_word();
			pending_items.push_back(it);
		end
		stim_done = 1'b1;
	end

	// ---------------- reset, driver, receiver ----------------
	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		item_valid = 1'b0;
		item = '0;
		mtx_stall = 1'b0;
		n_mismatch = 0;
		n_sent = 0;
		n_checked = 0;
		idle_cycles = 0;
		burst_left = 0;
		gap_left = 0;
		stall_phase = 0;
		stall_mode = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				expected_mtx.push_back(model_matrix(item));
				n_sent++;
			end
			if (!item_valid || !item_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					item_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					item <= pending_items.pop_front();
					item_valid <= 1'b1;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
					end else
						burst_left--;
				end else
					item_valid <= 1'b0;
			end
		end
	end

	// receiver stall: pattern mode re-chosen at random from four modes
	always @(posedge clk) begin
		if (arst_n) begin
			stall_phase++;
			if (stall_phase % 64 == 0)
				stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: mtx_stall <= 1'b0;
				1: mtx_stall <= ($urandom_range(0, 3) == 0);
				2: mtx_stall <= (stall_phase % 7) < 3;
				default: mtx_stall <= ($urandom_range(0, 1) == 1);
			endcase
		end
	end

	always @(posedge clk) begin
		trs_pkg::mtx_t exp_m;
		if (arst_n && mtx_valid && !mtx_stall) begin
			if (expected_mtx.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("unexpected transaction: %h", mtx);
			end else begin
				exp_m = expected_mtx.pop_front();
				n_checked++;
				if (exp_m !== mtx) begin
					n_mismatch++;
					if (n_mismatch <= 10) begin
						$display("mismatch on result %0d", n_checked);
						$display("  expected %h", exp_m);
						$display("  actual   %h", mtx);
					end
				end
			end
		end
	end

	// watchdog: cycles with no transaction on either side
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (mtx_valid && !mtx_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("watchdog expired, %0d results outstanding", expected_mtx.size());
			$display("** trs_model_matrix_unit: FAILED **");
			$finish;
		end
	end

	initial begin
		wait (stim_done);
		wait (pending_items.size() == 0 && !item_valid);
		wait (expected_mtx.size() == 0);
		repeat (DRAIN_CYC) @(posedge clk);
		$display("run covered %0d matrices checked of %0d items sent, %0d mismatches",
			n_checked, n_sent, n_mismatch);
		$display("angles at right angles, wrap-around and random; scales up to saturation");
		if (n_mismatch == 0 && expected_mtx.size() == 0)
			$display("** trs_model_matrix_unit: PASSED **");
		else
			$display("** trs_model_matrix_unit: FAILED **");
		$finish;
	end

endmodule

// File: files.f
hdl/trs_pkg.sv
hdl/trs_trig.sv
hdl/trs_model_matrix_unit.sv
tb/testbench.sv
